>>> rtl/mbt_pkg.sv
`timescale 1ns / 1ps

package mbt_pkg;

    localparam int GROUP_BITS  = 11;            // bits per group
    localparam int NUM_TRITS   = 7;             // base-3 digits per group
    localparam int BUF_BITS    = 10;            // leftover bits kept between bytes
    localparam int CNT_W       = 4;             // holds 0..10
    localparam int SUM_W       = 5;             // holds 0..18
    localparam int EXT_W       = 18;            // buffer plus one byte

    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // v / 81 == (v * 12946) >> 20 for all v < 2048
    localparam int RECIP_W     = 14;
    localparam int PROD_W      = GROUP_BITS + RECIP_W;
    localparam int RECIP_SHIFT = 20;
    localparam logic [RECIP_W-1:0] RECIP_81 = 14'd12946;
    localparam int HI_W        = 5;             // v / 81, 0..25
    localparam int LO_W        = 7;             // v % 81, 0..80

    // trit table: entry i holds four base-3 digits of i, lowest digit in low bits
    localparam int TAB_ENTRIES = 81;
    localparam int TAB_EW      = 8;
    localparam int TAB_W       = TAB_ENTRIES * TAB_EW;

    typedef struct packed {
        logic                  last;
        logic [GROUP_BITS-1:0] value;
    } group_t;

    typedef struct packed {
        logic [1:0] n;      // number of groups pushed this cycle, 0..2
        group_t     g0;     // older group
        group_t     g1;
    } push_t;

    function automatic logic [TAB_W-1:0] build_trit_tab();
        logic [TAB_W-1:0] tab;
        logic [1:0]       d [4];
        logic             carry;
        tab = '0;
        for (int k = 0; k < 4; k++)
        begin
            d[k] = 2'd0;
        end
        for (int i = 0; i < TAB_ENTRIES; i++)
        begin
            tab[i*TAB_EW +: TAB_EW] = {d[3], d[2], d[1], d[0]};
            carry = 1'b1;
            for (int k = 0; k < 4; k++)
            begin
                if (carry)
                begin
                    if (d[k] == 2'd2)
                    begin
                        d[k] = 2'd0;
                    end
                    else
                    begin
                        d[k] = d[k] + 2'd1;
                        carry = 1'b0;
                    end
                end
            end
        end
        return tab;
    endfunction

    localparam logic [TAB_W-1:0] TRIT_TAB = build_trit_tab();

endpackage

>>> rtl/message_bits_to_trits.sv
`timescale 1ns / 1ps

// Message bits to trits.
// Input stream: one message byte per word on s_tdata, bit 7 taken first;
// s_tlast marks the final byte of a message. Bits are gathered into 11-bit
// groups, the first bit in the group's lsb. Output stream: one group per
// word, as seven base-3 digits on m_tdata (2 bits each, lowest digit in the
// lowest bits); m_tlast marks the final group of the message. On the final
// byte any leftover bits are zero-padded into one more group, so a byte
// yields zero, one or two groups.
// Throughput: one byte per cycle while s_tready is high, one group per cycle
// out while m_tready is high. The front end packs bits and pushes up to two
// groups a cycle into a 4-deep queue; s_tready is high while the queue has
// room for two groups. A group is written to the queue on the edge that
// accepts the byte completing it, then passes the split stage and the digit
// table register before it shows on m_tvalid; a stall can hold it in either.
// Reset clears the bit buffer, the queue and both back-end stages.
// When m_tready is low the output word holds, the back end stalls, the
// queue fills and s_tready drops; nothing is lost.
module message_bits_to_trits
    import mbt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] msg_byte
    input  logic        s_tlast,    // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [1:0] trit0 .. [13:12] trit6, [15:14] zero
    output logic        m_tlast     // last_group
);

    push_t                  push;
    logic                   room;
    logic                   q_valid;
    logic                   q_pop;
    group_t                 q_data;
    logic [QCNT_W-1:0]      q_level;
    logic [2*NUM_TRITS-1:0] trits;
    logic                   accept;

    assign accept   = s_tvalid && room;
    assign s_tready = room;

    mbt_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .msg_byte  (s_tdata),
        .last_byte (s_tlast),
        .push      (push)
    );

    mbt_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .room     (room),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_data  (q_data),
        .level    (q_level)
    );

    mbt_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_trits (trits),
        .out_last  (m_tlast)
    );

    assign m_tdata = {2'b00, trits};

    // queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        q_level <= QCNT_W'(QDEPTH))
        else $error("group queue overflow");

    // no push without an accepted byte
    assert property (@(posedge clk) disable iff (!rst_n)
        !accept |-> (push.n == 2'd0))
        else $error("group pushed without input");

    // every digit is a valid trit
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[1:0] == 2'd3 || m_tdata[3:2] == 2'd3
            || m_tdata[5:4] == 2'd3 || m_tdata[7:6] == 2'd3
            || m_tdata[9:8] == 2'd3 || m_tdata[11:10] == 2'd3
            || m_tdata[13:12] == 2'd3))
        else $error("digit out of range");

endmodule

>>> rtl/mbt_front.sv
`timescale 1ns / 1ps

module mbt_front
    import mbt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] msg_byte,
    input  logic       last_byte,
    output push_t      push
);

    logic [BUF_BITS-1:0] buf_reg, buf_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    logic [7:0]       rev;
    logic [EXT_W-1:0] ext;
    logic [EXT_W-1:0] rem;
    logic [SUM_W-1:0] tot;
    logic [SUM_W-1:0] rem_cnt;
    logic             full;
    logic             flush;
    group_t           g_full;
    group_t           g_pad;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            rev[i] = msg_byte[7-i];
        end
        // bit 7 of the byte goes to the lowest free position
        ext     = {8'b0, buf_reg} | ({10'b0, rev} << cnt_reg);
        tot     = {1'b0, cnt_reg} + SUM_W'(8);
        full    = (tot >= SUM_W'(GROUP_BITS));
        rem     = full ? (ext >> GROUP_BITS) : ext;
        rem_cnt = full ? (tot - SUM_W'(GROUP_BITS)) : tot;
        flush   = last_byte && (rem_cnt != '0);

        g_full.value = ext[GROUP_BITS-1:0];
        g_full.last  = last_byte && (rem_cnt == '0);
        g_pad.value  = rem[GROUP_BITS-1:0];
        g_pad.last   = 1'b1;

        push.n  = 2'd0;
        push.g0 = g_full;
        push.g1 = g_pad;
        if (accept)
        begin
            if (full && flush)
            begin
                push.n = 2'd2;
            end
            else if (full)
            begin
                push.n = 2'd1;
            end
            else if (flush)
            begin
                push.n  = 2'd1;
                push.g0 = g_pad;
            end
        end

        buf_next = buf_reg;
        cnt_next = cnt_reg;
        if (accept)
        begin
            if (last_byte)
            begin
                buf_next = '0;
                cnt_next = '0;
            end
            else
            begin
                buf_next = rem[BUF_BITS-1:0];
                cnt_next = rem_cnt[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            buf_reg <= buf_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> rtl/mbt_queue.sv
`timescale 1ns / 1ps

module mbt_queue
    import mbt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  push_t             push,
    output logic              room,     // space for two more groups
    output logic              rd_valid,
    input  logic              rd_pop,
    output group_t            rd_data,
    output logic [QCNT_W-1:0] level
);

    group_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                pop;

    assign room     = (cnt_reg <= QCNT_W'(QDEPTH - 2));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign level    = cnt_reg;
    assign pop      = rd_valid && rd_pop;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push.n);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(pop);
        cnt_next    = cnt_reg + QCNT_W'(push.n) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.g0;
        end
        if (push.n == 2'd2)
        begin
            mem_reg[wr_ptr_reg + QPTR_W'(1)] <= push.g1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

>>> rtl/mbt_back.sv
`timescale 1ns / 1ps

module mbt_back
    import mbt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  group_t       q_data,
    output logic         q_pop,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [2*NUM_TRITS-1:0] out_trits,
    output logic         out_last
);

    // stage 1: split v into v/81 and v%81
    logic             s1_valid_reg, s1_valid_next;
    logic [HI_W-1:0]  hi_reg, hi_next;
    logic [LO_W-1:0]  lo_reg, lo_next;
    logic             s1_last_reg, s1_last_next;

    // stage 2: output register
    logic                   out_valid_reg, out_valid_next;
    logic [2*NUM_TRITS-1:0] trits_reg, trits_next;
    logic                   last_reg, last_next;

    logic                   s1_adv;
    logic                   s1_open;
    logic [PROD_W-1:0]      prod;
    logic [GROUP_BITS-1:0]  hi_x81;
    logic [GROUP_BITS-1:0]  lo_full;
    logic [TAB_EW-1:0]      lo_trits;
    logic [TAB_EW-1:0]      hi_trits;

    assign s1_adv  = !out_valid_reg || out_ready;
    assign s1_open = !s1_valid_reg || s1_adv;
    assign q_pop   = q_valid && s1_open;

    always_comb
    begin
        prod    = PROD_W'(q_data.value) * PROD_W'(RECIP_81);
        hi_next = prod[RECIP_SHIFT +: HI_W];
        hi_x81  = (GROUP_BITS'(hi_next) << 6) + (GROUP_BITS'(hi_next) << 4)
                + GROUP_BITS'(hi_next);
        lo_full = q_data.value - hi_x81;
        lo_next = lo_full[LO_W-1:0];
        s1_last_next  = q_data.last;
        s1_valid_next = s1_open ? q_valid : s1_valid_reg;

        lo_trits   = TRIT_TAB[{lo_reg, 3'b000} +: TAB_EW];
        hi_trits   = TRIT_TAB[{hi_reg, 3'b000} +: TAB_EW];
        trits_next = {hi_trits[5:0], lo_trits};
        last_next  = s1_last_reg;
        out_valid_next = s1_adv ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            hi_reg      <= hi_next;
            lo_reg      <= lo_next;
            s1_last_reg <= s1_last_next;
        end
        if (s1_adv && s1_valid_reg)
        begin
            trits_reg <= trits_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_trits = trits_reg;
    assign out_last  = last_reg;

endmodule

>>> test/message_bits_to_trits_test.sv
`timescale 1ns / 1ps

module message_bits_to_trits_test;
    import mbt_pkg::*;

    // one output word as seen on the master side
    typedef struct packed {
        logic        last;
        logic [15:0] word;
    } group_word_t;

    // directed stimulus row; when typed is set, n/g0/g1 hold the expected groups
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        typed;
        logic [1:0]  n;
        group_word_t g0;
        group_word_t g1;
    } stim_row_t;

    localparam group_word_t ZERO_MID = '{1'b0, 16'h0000};
    localparam group_word_t ZERO_END = '{1'b1, 16'h0000};

    localparam int NUM_ROWS = 17;
    localparam stim_row_t DIRECTED [NUM_ROWS] = '{
        '{8'h00, 1'b1, 1'b1, 2'd1, ZERO_END, ZERO_MID},  // lone zero byte: one padded group
        '{8'h00, 1'b0, 1'b1, 2'd0, ZERO_MID, ZERO_MID},
        '{8'h00, 1'b1, 1'b1, 2'd2, ZERO_MID, ZERO_END},  // full group then padded tail
        '{8'hFF, 1'b1, 1'b0, 2'd0, ZERO_MID, ZERO_MID},
        '{8'hFF, 1'b0, 1'b0, 2'd0, ZERO_MID, ZERO_MID},
        '{8'hFF, 1'b1, 1'b0, 2'd0, ZERO_MID, ZERO_MID},  // all-ones group 2047
        // 88 bits: last byte closes a group exactly, no padded group
        '{8'hA5, 1'b0, 1'b0, 2'd0, ZERO_MID, ZERO_MID},
        '{8'h5A, 1'b0, 1'b0, 2'd0, ZERO_MID, ZERO_MID},
        '{8'hFF, 1'b0, 1'b0, 2'd0, ZERO_MID, ZERO_MID},
        '{8'h80, 1'b0, 1'b0, 2'd0, ZERO_MID, ZERO_MID},
        '{8'h01, 1'b0, 1'b0, 2'd0, ZERO_MID, ZERO_MID},
        '{8'h7F, 1'b0, 1'b0, 2'd0, ZERO_MID, ZERO_MID},
        '{8'hFE, 1'b0, 1'b0, 2'd0, ZERO_MID, ZERO_MID},
        '{8'hC3, 1'b0, 1'b0, 2'd0, ZERO_MID, ZERO_MID},
        '{8'h3C, 1'b0, 1'b0, 2'd0, ZERO_MID, ZERO_MID},
        '{8'h00, 1'b0, 1'b0, 2'd0, ZERO_MID, ZERO_MID},
        '{8'hFF, 1'b1, 1'b0, 2'd0, ZERO_MID, ZERO_MID}
    };

    localparam int BYTES_PER_PHASE = 135;
    localparam int NUM_PHASES      = 4;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    // predictor state: pending message bits, oldest in bit 0
    logic [17:0] pend_bits;
    int          pend_cnt;

    group_word_t exp_groups [$];

    int send_idle_pct;
    int recv_stall_pct;
    int fail_count;
    int bytes_sent;
    int msgs_sent;
    int groups_seen;

    message_bits_to_trits u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [7:0] msg_byte
        .s_tlast  (s_tlast),    // last_byte
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [1:0] trit0 .. [13:12] trit6, [15:14] zero
        .m_tlast  (m_tlast)     // last_group
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [15:0] trit_word(input logic [10:0] value);
        logic [15:0] w;
        int          rem;
        w = '0;
        rem = value;
        for (int k = 0; k < NUM_TRITS; k++)
        begin
            w[2*k +: 2] = 2'(rem % 3);
            rem = rem / 3;
        end
        return w;
    endfunction

    // advance the bit packer by one byte; returns the number of groups it emits
    function automatic int predict_groups(input logic [7:0] data, input logic last,
                                          output group_word_t g0, output group_word_t g1);
        logic [17:0] rev;
        int          n;
        rev = '0;
        n = 0;
        g0 = ZERO_MID;
        g1 = ZERO_MID;
        for (int i = 0; i < 8; i++)
        begin
            rev[i] = data[7-i];
        end
        pend_bits = pend_bits | (rev << pend_cnt);
        pend_cnt = pend_cnt + 8;
        if (pend_cnt >= GROUP_BITS)
        begin
            g0.word = trit_word(pend_bits[10:0]);
            pend_bits = pend_bits >> GROUP_BITS;
            pend_cnt = pend_cnt - GROUP_BITS;
            g0.last = last && (pend_cnt == 0);
            n = 1;
        end
        if (last)
        begin
            if (pend_cnt > 0)
            begin
                if (n == 0)
                begin
                    g0 = '{1'b1, trit_word(pend_bits[10:0])};
                end
                else
                begin
                    g1 = '{1'b1, trit_word(pend_bits[10:0])};
                end
                n = n + 1;
            end
            pend_bits = '0;
            pend_cnt = 0;
        end
        return n;
    endfunction

    // present one byte, hold it until taken, then book its groups
    task automatic send_byte(input stim_row_t row);
        group_word_t p0;
        group_word_t p1;
        int          n;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= row.data;
        s_tlast  <= row.last;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        n = predict_groups(row.data, row.last, p0, p1);
        if (row.typed)
        begin
            n = row.n;
            p0 = row.g0;
            p1 = row.g1;
        end
        if (n > 0)
        begin
            exp_groups.push_back(p0);
        end
        if (n > 1)
        begin
            exp_groups.push_back(p1);
        end
        bytes_sent++;
        if (row.last)
        begin
            msgs_sent++;
        end
    endtask

    task automatic send_random_message();
        stim_row_t row;
        int        len;
        int        pick;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
        row = '0;
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(0, 9);
            row.data = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(0, 255));
            row.last = (i == len - 1);
            send_byte(row);
        end
    endtask

    // output stall pattern, redrawn every cycle
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin : watch_groups
        group_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            groups_seen++;
            if (exp_groups.size() == 0)
            begin
                $display("%0t: unexpected word: tdata=%h tlast=%b", $realtime, m_tdata, m_tlast);
                fail_count++;
            end
            else
            begin
                want = exp_groups.pop_front();
                // index 7 is the zero pad above trit6
                for (int k = 0; k < 8; k++)
                begin
                    if (m_tdata[2*k +: 2] !== want.word[2*k +: 2])
                    begin
                        $display("%0t: trit%0d mismatch: expected %0d, actual %0d",
                                 $realtime, k, want.word[2*k +: 2], m_tdata[2*k +: 2]);
                        fail_count++;
                    end
                end
                if (m_tlast !== want.last)
                begin
                    $display("%0t: last_group mismatch: expected %b, actual %b",
                             $realtime, want.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int phase_bytes;
        pend_bits = '0;
        pend_cnt = 0;
        fail_count = 0;
        bytes_sent = 0;
        msgs_sent = 0;
        groups_seen = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            send_byte(DIRECTED[i]);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            phase_bytes = bytes_sent;
            while (bytes_sent - phase_bytes < BYTES_PER_PHASE)
            begin
                send_random_message();
            end
        end
        s_tvalid <= 1'b0;

        while (exp_groups.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        $display("Sent %0d bytes in %0d messages, checked %0d trit words", bytes_sent,
                 msgs_sent, groups_seen);
        $display("Covered free flow, input gaps, output stalls and mixed idling");
        if (fail_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
